FILE: rtl/core/tmcw_pkg.sv
package tmcw_pkg;

  localparam int COLUMNS       = 80;
  localparam int ROWS          = 50;
  localparam int CELL_COUNT    = COLUMNS * ROWS;
  localparam int ADDR_W        = $clog2(CELL_COUNT);
  localparam int LAST_ROW_BASE = (ROWS - 1) * COLUMNS;

  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] RESET_ATTR   = 8'h0F;

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  character;
    logic [7:0]  attribute;
    logic [11:0] read_address;
  } cmd_t;

  typedef struct packed {
    logic [15:0] cell_value;
    logic [6:0]  cursor_column;
    logic [5:0]  cursor_row;
    logic [11:0] cursor_position;
  } res_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_READ,
    S_FILL,
    S_SCROLL,
    S_BLANK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic idle;
    logic done;
  } eng_status_t;

  function automatic logic [ADDR_W-1:0] cell_index(input logic [5:0] line,
                                                   input logic [6:0] col);
    cell_index = ADDR_W'(32'(line) * COLUMNS + 32'(col));
  endfunction

endpackage

FILE: rtl/core/tmcw_engine.sv
module tmcw_engine import tmcw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  cmd_t        cmd,
  input  logic        res_free,
  output eng_status_t status,
  output res_t        result
);

  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] ROW_BASE  = ADDR_W'(LAST_ROW_BASE);

  logic [15:0] cells [CELL_COUNT];
  logic [15:0] rd_data;

  state_t            state, state_next;
  logic [6:0]        col, col_next;
  logic [5:0]        line, line_next;
  logic [ADDR_W-1:0] ptr, ptr_next;
  logic [ADDR_W-1:0] wr_addr, wr_addr_next;
  logic              pend, pend_next;
  logic [15:0]       fill, fill_next;
  logic [15:0]       value, value_next;

  logic              we;
  logic [ADDR_W-1:0] wa, ra;
  logic [15:0]       wd;

  logic [6:0]  line_inc;
  logic        line_over;
  logic [7:0]  col_inc;
  logic [6:0]  col_bs;
  logic [15:0] blank_in;

  always_ff @(posedge clk) begin
    if (we) begin
      cells[wa] <= wd;
    end
    rd_data <= cells[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_INIT;
      col     <= '0;
      line    <= 6'd1;
      ptr     <= '0;
      pend    <= 1'b0;
      fill    <= {RESET_ATTR, CH_SPACE};
    end else begin
      state   <= state_next;
      col     <= col_next;
      line    <= line_next;
      ptr     <= ptr_next;
      pend    <= pend_next;
      fill    <= fill_next;
    end
    wr_addr <= wr_addr_next;
    value   <= value_next;
  end

  always_comb begin
    line_inc  = {1'b0, line} + 7'd1;
    line_over = (line_inc == 7'(ROWS));
    col_inc   = {1'b0, col} + 8'd1;
    col_bs    = (col == 7'd0) ? col : col - 7'd1;
    blank_in  = {cmd.attribute, CH_SPACE};

    state_next   = state;
    col_next     = col;
    line_next    = line;
    ptr_next     = ptr;
    wr_addr_next = wr_addr;
    pend_next    = pend;
    fill_next    = fill;
    value_next   = value;
    we = 1'b0;
    wa = ptr;
    wd = fill;
    ra = ptr;

    case (state)
      S_INIT, S_FILL, S_BLANK: begin
        we = 1'b1;
        if (ptr == LAST_CELL) begin
          ptr_next   = '0;
          state_next = (state == S_INIT) ? S_IDLE : S_DONE;
        end else begin
          ptr_next = ptr + ADDR_W'(1);
        end
      end
      S_IDLE: begin
        if (start) begin
          value_next = '0;
          fill_next  = blank_in;
          state_next = S_DONE;
          case (cmd.op)
            OP_PUT: begin
              if (cmd.character == CH_BACKSPACE) begin
                we       = 1'b1;
                wa       = cell_index(line, col_bs);
                wd       = blank_in;
                col_next = col_bs;
              end else begin
                if (cmd.character != CH_NEWLINE) begin
                  we = 1'b1;
                  wa = cell_index(line, col);
                  wd = {cmd.attribute, cmd.character};
                end
                if (cmd.character == CH_NEWLINE || col_inc == 8'(COLUMNS)) begin
                  col_next = '0;
                  if (line_over) begin
                    // Past the bottom: copy every row one up, then blank the last row.
                    line_next  = 6'(ROWS - 1);
                    ptr_next   = '0;
                    pend_next  = 1'b0;
                    state_next = S_SCROLL;
                  end else begin
                    line_next = line_inc[5:0];
                  end
                end else begin
                  col_next = col_inc[6:0];
                end
              end
            end
            OP_READ: begin
              if (32'(cmd.read_address) < 32'(CELL_COUNT)) begin
                ra         = ADDR_W'(cmd.read_address);
                state_next = S_READ;
              end
            end
            OP_CLEAR: begin
              col_next   = '0;
              line_next  = 6'd1;
              ptr_next   = '0;
              state_next = S_FILL;
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_READ: begin
        value_next = rd_data;
        state_next = S_DONE;
      end
      S_SCROLL: begin
        // Read one row ahead and write back the data read the cycle before.
        if (pend) begin
          we = 1'b1;
          wa = wr_addr;
          wd = rd_data;
        end
        if (ptr != ROW_BASE) begin
          ra           = ptr + ADDR_W'(COLUMNS);
          pend_next    = 1'b1;
          wr_addr_next = ptr;
          ptr_next     = ptr + ADDR_W'(1);
        end else begin
          pend_next  = 1'b0;
          state_next = S_BLANK;
        end
      end
      S_DONE: begin
        if (res_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign status.idle = (state == S_IDLE);
  assign status.done = (state == S_DONE);

  assign result.cell_value      = value;
  assign result.cursor_column   = col;
  assign result.cursor_row      = line;
  assign result.cursor_position = 12'(cell_index(line, col));

endmodule

FILE: rtl/core/text_mode_console_writer.sv
// Flow: a put, an unused op or an out-of-range read goes from idle straight to done after
// acceptance, an in-range read via S_READ, a scrolling put via S_SCROLL and S_BLANK and a clear
// via S_FILL, which both walk the single cell memory one entry per cycle.
// Handshake: one transaction is in work at a time and cmd_stall stays high until the engine
// is idle, so a new command is only taken once the last result has moved to the output register.
// Synchronous reset blanks all 4000 cells with attribute 0x0F before the first command.
module text_mode_console_writer import tmcw_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_stall,
  input  cmd_t cmd,
  output logic res_valid,
  input  logic res_stall,
  output res_t res
);

  eng_status_t status;
  res_t        eng_res;
  logic        res_free;

  assign res_free  = !res_valid || !res_stall;
  assign cmd_stall = !status.idle;

  tmcw_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd_valid && status.idle),
    .cmd      (cmd),
    .res_free (res_free),
    .status   (status),
    .result   (eng_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (status.done && res_free) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
    if (status.done && res_free) begin
      res <= eng_res;
    end
  end

endmodule

FILE: dv/console_checker.sv
`timescale 1ns / 100ps

module console_checker import tmcw_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  input  logic cmd_stall,
  input  cmd_t cmd,
  input  logic res_valid,
  input  logic res_stall,
  input  res_t res,
  output int   error_count,
  output int   awaited_count
);

  localparam int HOME_ROW = 1;

  logic [15:0] screen_image [CELL_COUNT];
  int          col_now;
  int          row_now;
  res_t        awaited_results [$];
  int          fails = 0;

  function automatic void blank_screen(input logic [7:0] attr);
    int i;
    for (i = 0; i < CELL_COUNT; i++) begin
      screen_image[i] = {attr, CH_SPACE};
    end
  endfunction

  // The whole store moves up one row, row 0 included, and the last row is blanked.
  function automatic void scroll_if_past_bottom(input logic [7:0] attr);
    int i;
    if (row_now >= ROWS) begin
      for (i = 0; i < CELL_COUNT - COLUMNS; i++) begin
        screen_image[i] = screen_image[i + COLUMNS];
      end
      for (i = 0; i < COLUMNS; i++) begin
        screen_image[LAST_ROW_BASE + i] = {attr, CH_SPACE};
      end
      row_now = ROWS - 1;
    end
  endfunction

  function automatic res_t console_outcome(input cmd_t c);
    res_t r;
    r = '0;
    case (c.op)
      OP_PUT: begin
        if (c.character == CH_NEWLINE) begin
          col_now = 0;
          row_now++;
          scroll_if_past_bottom(c.attribute);
        end else if (c.character == CH_BACKSPACE) begin
          // Backspace at column 0 stays there but still blanks the cell.
          if (col_now > 0) begin
            col_now--;
          end
          screen_image[row_now * COLUMNS + col_now] = {c.attribute, CH_SPACE};
        end else begin
          screen_image[row_now * COLUMNS + col_now] = {c.attribute, c.character};
          col_now++;
          if (col_now >= COLUMNS) begin
            col_now = 0;
            row_now++;
          end
          scroll_if_past_bottom(c.attribute);
        end
      end
      OP_READ: begin
        if (int'(c.read_address) < CELL_COUNT) begin
          r.cell_value = screen_image[c.read_address];
        end
      end
      OP_CLEAR: begin
        blank_screen(c.attribute);
        col_now = 0;
        row_now = HOME_ROW;
      end
      default: ;
    endcase
    r.cursor_column   = 7'(col_now);
    r.cursor_row      = 6'(row_now);
    r.cursor_position = 12'(row_now * COLUMNS + col_now);
    return r;
  endfunction

  task automatic compare_field(input string field, input int want, input int got);
    if (want != got) begin
      fails++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      blank_screen(RESET_ATTR);
      col_now = 0;
      row_now = HOME_ROW;
      awaited_results.delete();
    end else begin
      if (cmd_valid && !cmd_stall) begin
        awaited_results.push_back(console_outcome(cmd));
      end
      if (res_valid && !res_stall) begin
        if (awaited_results.size() == 0) begin
          fails++;
          $display("%0t: result with none expected, expected nothing, actual %h",
                   $time, res);
        end else begin
          want = awaited_results.pop_front();
          compare_field("cell_value", want.cell_value, res.cell_value);
          compare_field("cursor_column", want.cursor_column, res.cursor_column);
          compare_field("cursor_row", want.cursor_row, res.cursor_row);
          compare_field("cursor_position", want.cursor_position, res.cursor_position);
        end
      end
    end
    error_count   <= fails;
    awaited_count <= awaited_results.size();
  end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps

module tb import tmcw_pkg::*;;

  localparam logic [1:0] OP_NONE   = 2'd3;
  localparam int         ITEM_GOAL = 1500;
  localparam int         LONG_HOLD = 300;
  localparam int         DRAIN_MAX = 20000;

  logic clk = 1'b0;
  logic rst;
  logic cmd_valid;
  logic cmd_stall;
  cmd_t cmd;
  logic res_valid;
  logic res_stall;
  res_t res;
  int   error_count;
  int   awaited_count;

  int   send_max = 15;
  int   item_total = 0;

  always #10 clk = ~clk;

  text_mode_console_writer dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  console_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd_valid),
    .cmd_stall     (cmd_stall),
    .cmd           (cmd),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .res           (res),
    .error_count   (error_count),
    .awaited_count (awaited_count)
  );

  function automatic cmd_t cmd_of(input logic [1:0] op, input logic [7:0] ch,
                                  input logic [7:0] attr, input logic [11:0] addr);
    cmd_t c;
    c.op           = op;
    c.character    = ch;
    c.attribute    = attr;
    c.read_address = addr;
    return c;
  endfunction

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Reads lean toward the bottom rows, where text lands once the screen scrolls.
  function automatic logic [11:0] pick_address();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) begin
      return 12'(LAST_ROW_BASE - COLUMNS + $urandom_range(0, 2 * COLUMNS - 1));
    end else if (r < 6) begin
      return 12'($urandom_range(0, 4 * COLUMNS - 1));
    end else if (r < 9) begin
      return 12'($urandom_range(0, CELL_COUNT - 1));
    end
    return 12'($urandom_range(0, 4095));
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic issue(input cmd_t c);
    int gap;
    gap = $urandom_range(0, send_max);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd       <= c;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    if (c.op != OP_NONE) begin
      item_total++;
    end
    @(negedge clk);
  endtask

  task automatic put_char(input logic [7:0] ch);
    issue(cmd_of(OP_PUT, ch, any_byte(), 12'($urandom_range(0, 4095))));
  endtask

  initial begin : result_sink
    int hold;
    int taken;
    int recv_max;
    taken    = 0;
    recv_max = 15;
    res_stall = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (taken % 50 == 0) begin
        recv_max = ($urandom_range(0, 2) == 0) ? 0 : 15;
      end
      hold = $urandom_range(0, recv_max);
      // Long hold-off so the pending result backs up into the command side.
      if (taken == 300 || taken == 1000) begin
        hold = LONG_HOLD;
      end
      if (hold > 0) begin
        res_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      res_stall <= 1'b0;
      @(posedge clk);
      while (!res_valid) @(posedge clk);
      taken++;
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int kind;
    int len;
    int k;
    int drain;
    rst       = 1'b1;
    cmd_valid = 1'b0;
    cmd       = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset contents, read bounds, writes, backspace down to column 0,
    // newline, the unused op and clears with extreme attributes.
    issue(cmd_of(OP_READ, 8'h00, 8'h00, 12'd0));
    issue(cmd_of(OP_READ, 8'hFF, 8'hFF, 12'(CELL_COUNT - 1)));
    issue(cmd_of(OP_READ, 8'h00, 8'h00, 12'(CELL_COUNT)));
    issue(cmd_of(OP_READ, 8'h00, 8'h00, 12'hFFF));
    issue(cmd_of(OP_PUT, 8'h41, 8'h00, 12'h000));
    issue(cmd_of(OP_PUT, 8'hFF, 8'hFF, 12'hFFF));
    issue(cmd_of(OP_PUT, 8'h00, 8'h80, 12'h000));
    issue(cmd_of(OP_READ, 8'h00, 8'h00, 12'(COLUMNS + 1)));
    issue(cmd_of(OP_PUT, CH_BACKSPACE, 8'h12, 12'h000));
    issue(cmd_of(OP_PUT, CH_BACKSPACE, 8'h34, 12'h000));
    issue(cmd_of(OP_PUT, CH_BACKSPACE, 8'h56, 12'h000));
    issue(cmd_of(OP_PUT, CH_BACKSPACE, 8'h78, 12'h000));
    issue(cmd_of(OP_READ, 8'h00, 8'h00, 12'(COLUMNS)));
    issue(cmd_of(OP_READ, 8'h00, 8'h00, 12'(COLUMNS + 1)));
    issue(cmd_of(OP_PUT, CH_NEWLINE, 8'hA5, 12'h000));
    issue(cmd_of(OP_NONE, 8'hFF, 8'hFF, 12'hFFF));
    issue(cmd_of(OP_CLEAR, 8'hAA, 8'hFF, 12'hFFF));
    issue(cmd_of(OP_READ, 8'h00, 8'h00, 12'd0));
    issue(cmd_of(OP_READ, 8'h00, 8'h00, 12'(CELL_COUNT - 1)));
    issue(cmd_of(OP_PUT, 8'h7E, 8'h3C, 12'h000));
    issue(cmd_of(OP_CLEAR, 8'h00, 8'h00, 12'h000));
    issue(cmd_of(OP_READ, 8'h00, 8'h00, 12'(COLUMNS)));

    while (item_total < ITEM_GOAL) begin
      kind     = $urandom_range(0, 99);
      send_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
      if (kind < 55) begin
        len = $urandom_range(3, 40);
        for (k = 0; k < len; k++) begin
          put_char(($urandom_range(0, 11) == 0) ? CH_BACKSPACE : any_byte());
        end
        if ($urandom_range(0, 1) == 1) begin
          put_char(CH_NEWLINE);
        end
      end else if (kind < 75) begin
        len = $urandom_range(2, 8);
        for (k = 0; k < len; k++) begin
          issue(cmd_of(OP_READ, any_byte(), any_byte(), pick_address()));
        end
      end else if (kind < 87) begin
        // A run of newlines walks the cursor toward the bottom and scrolls once it passes it.
        len = $urandom_range(5, 30);
        for (k = 0; k < len; k++) begin
          put_char(CH_NEWLINE);
        end
      end else if (kind < 90) begin
        issue(cmd_of(OP_CLEAR, any_byte(), any_byte(), 12'($urandom_range(0, 4095))));
      end else begin
        len = $urandom_range(1, 5);
        for (k = 0; k < len; k++) begin
          issue(cmd_of(2'($urandom_range(0, 3)), any_byte(), any_byte(),
                       12'($urandom_range(CELL_COUNT, 4095))));
        end
      end
    end
    cmd_valid <= 1'b0;

    drain = 0;
    while (awaited_count != 0 && drain < DRAIN_MAX) begin
      @(posedge clk);
      drain++;
    end
    repeat (10) @(posedge clk);
    if (error_count == 0 && awaited_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #600000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
